// File: design/ecp_pkg.sv
// Shared types, constants and helpers for the expert usage checkpoint policy block.
`timescale 1ns / 1ps
package ecp_pkg;

	localparam int unsigned MaxExperts  = 256;
	localparam int unsigned IdxBits     = 8;
	localparam int unsigned CountBits   = 24;
	localparam int unsigned LogFracBits = 16;
	localparam int unsigned LogBits     = 5 + LogFracBits;

	localparam logic [CountBits-1:0] CountMax = '1;

	localparam logic [1:0] RegExpertCount   = 2'd0;
	localparam logic [1:0] RegEntropyLimit  = 2'd1;
	localparam logic [1:0] RegImbalanceLimit = 2'd2;

	localparam logic OpRecord = 1'b0;
	localparam logic OpClear  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REC,
		ST_EV_RD,
		ST_EV_CNT,
		ST_LOG_NORM,
		ST_LOG_SQ,
		ST_CLOG,
		ST_FIN,
		ST_TL,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_M7,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		LOG_CNT,
		LOG_TOT,
		LOG_N
	} log_kind_t;

	typedef struct packed {
		logic                 clear;
		logic [IdxBits-1:0]   rd_addr;
		logic                 wr_en;
		logic [IdxBits-1:0]   wr_addr;
		logic [CountBits-1:0] wr_data;
	} mem_ctrl_t;

	function automatic logic [4:0] top_bit(input logic [31:0] x);
		logic [4:0] r;
		r = '0;
		for (int j = 0; j < 32; j++) begin
			if (x[j]) begin
				r = 5'(j);
			end
		end
		return r;
	endfunction

endpackage

// File: design/ecp_count_mem.sv
// Per-expert usage counter memory with valid bits so that a clear resets every count at once.
`timescale 1ns / 1ps
module ecp_count_mem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ecp_pkg::mem_ctrl_t                ctrl,
	output logic [ecp_pkg::CountBits-1:0]     count
);
	import ecp_pkg::*;

	logic [CountBits-1:0] mem [MaxExperts];
	logic [MaxExperts-1:0] valid_q;
	logic [CountBits-1:0] rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			rvld_q <= valid_q[ctrl.rd_addr];
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[ctrl.rd_addr];
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
	end

	assign count = rvld_q ? rdata_q : '0;

endmodule

// File: design/expert_usage_checkpoint_policy_core.sv
// Top level: request handling, evaluation sequencer and the shared multiplier.
`timescale 1ns / 1ps
// Counts routed expert indices and decides on checkpoints at the end of a batch.
// Input requests arrive on the s_axis channel: tdata carries the operation (bit 0,
// record or clear) and the signed expert index (bits 9:1); tlast ends a batch.
// After its record or clear, a request with tlast runs an evaluation:
// each expert in use is read, and one with a nonzero count also has its
// fixed-point log2 taken, which needs 16 squarings on the one shared
// 32x32 multiplier; the tail adds two more logarithms and seven product
// and compare steps, and is skipped when the usage total is zero.
// s_axis_tready is low while a request or evaluation is in progress. The result
// request appears on the m_axis channel from an output register; a waiting result
// does not stop new requests, but the next evaluation holds until the receiver
// has taken it.
// Reset clears all usage counts at once, empties the output register and loads the
// configuration defaults: 8 experts and limits 52429 and 19661. The user writes the
// configuration via cfg_we, cfg_index, cfg_wdata only while idle (not enforced).
module expert_usage_checkpoint_policy_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // operation, expert_index, zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // take_checkpoint, entropy_high, imbalance_high,
	                                   // usage_total, zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import ecp_pkg::*;

	state_t state_q, state_d;
	mem_ctrl_t mctl;
	logic [CountBits-1:0] count;

	logic [8:0]  n_q;
	logic [15:0] ent_lim_q, imb_lim_q;
	logic        op_q, last_q;
	logic [8:0]  idx_q;
	logic [IdxBits-1:0] i_q;
	logic [31:0] total_q;
	logic [CountBits-1:0] maxc_q, c_q;
	logic [63:0] clog_q, s_q;
	logic [31:0] log_x_q, m_q;
	logic [4:0]  k_q;
	logic [LogFracBits-1:0] frac_q;
	logic [3:0]  step_q;
	log_kind_t   kind_q;
	logic [39:0] a_q, nm_q;
	logic [24:0] b_q;
	logic [79:0] rhs_q;
	logic        ent_q, imb_q;
	logic        out_vld_q;
	logic [39:0] out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [LogBits-1:0] log_val;
	logic [4:0]  k_c;
	logic        idx_ok, last_i, out_free;
	logic [IdxBits-1:0] in_idx;

	assign log_val  = {k_q, frac_q};
	assign k_c      = top_bit(log_x_q);
	assign idx_ok   = !idx_q[8] && (idx_q < n_q);
	assign last_i   = ({1'b0, i_q} == (n_q - 9'd1));
	assign out_free = !out_vld_q || m_axis_tready;
	assign in_idx   = s_axis_tdata[IdxBits:1];
	assign prod     = 64'(mul_a) * 64'(mul_b);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	ecp_count_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctl),
		.count  (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mctl.clear   = 1'b0;
		mctl.rd_addr = i_q;
		mctl.wr_en   = 1'b0;
		mctl.wr_addr = idx_q[IdxBits-1:0];
		mctl.wr_data = (count == CountMax) ? count : count + 1'b1;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			ST_IDLE: begin
				mctl.rd_addr = in_idx;
				if (s_axis_tvalid) begin
					state_d = ST_REC;
				end
			end
			ST_REC: begin
				mctl.clear = (op_q == OpClear);
				mctl.wr_en = (op_q == OpRecord) && idx_ok;
				state_d    = last_q ? ST_EV_RD : ST_IDLE;
			end
			ST_EV_RD: state_d = ST_EV_CNT;
			ST_EV_CNT: begin
				if (count != '0) begin
					state_d = ST_LOG_NORM;
				end else begin
					state_d = last_i ? ST_FIN : ST_EV_RD;
				end
			end
			ST_LOG_NORM: state_d = ST_LOG_SQ;
			ST_LOG_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
				if (step_q == 4'(LogFracBits - 1)) begin
					case (kind_q)
						LOG_CNT: state_d = ST_CLOG;
						LOG_TOT: state_d = ST_TL;
						default: state_d = ST_M1;
					endcase
				end
			end
			ST_CLOG: begin
				mul_a   = 32'(c_q);
				mul_b   = 32'(log_val);
				state_d = last_i ? ST_FIN : ST_EV_RD;
			end
			ST_FIN: state_d = (total_q == '0) ? ST_OUT : ST_LOG_NORM;
			ST_TL: begin
				mul_a   = total_q;
				mul_b   = 32'(log_val);
				state_d = ST_LOG_NORM;
			end
			ST_M1: begin
				mul_a   = 32'(ent_lim_q);
				mul_b   = 32'(log_val);
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a   = a_q[31:0];
				mul_b   = total_q;
				state_d = ST_M3;
			end
			ST_M3: begin
				mul_a   = 32'(a_q[39:32]);
				mul_b   = total_q;
				state_d = ST_M4;
			end
			ST_M4: begin
				mul_a   = 32'(n_q);
				mul_b   = 32'(maxc_q);
				state_d = ST_M5;
			end
			ST_M5: begin
				mul_a   = 32'(imb_lim_q);
				mul_b   = 32'(n_q);
				state_d = ST_M6;
			end
			ST_M6: begin
				mul_a   = 32'(b_q);
				mul_b   = total_q;
				state_d = ST_M7;
			end
			ST_M7: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= 9'd8;
			ent_lim_q <= 16'd52429;
			imb_lim_q <= 16'd19661;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegExpertCount: begin
						if (cfg_wdata[8:0] < 9'd2) begin
							n_q <= 9'd2;
						end else if (cfg_wdata[8:0] > 9'(MaxExperts)) begin
							n_q <= 9'(MaxExperts);
						end else begin
							n_q <= cfg_wdata[8:0];
						end
					end
					RegEntropyLimit:   ent_lim_q <= cfg_wdata;
					RegImbalanceLimit: imb_lim_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q   <= s_axis_tdata[0];
				idx_q  <= s_axis_tdata[9:1];
				last_q <= s_axis_tlast;
			end
			ST_REC: begin
				i_q     <= '0;
				total_q <= '0;
				maxc_q  <= '0;
				clog_q  <= '0;
			end
			ST_EV_CNT: begin
				total_q <= total_q + 32'(count);
				if (count > maxc_q) begin
					maxc_q <= count;
				end
				c_q     <= count;
				log_x_q <= 32'(count);
				kind_q  <= LOG_CNT;
				if (count == '0) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_LOG_NORM: begin
				k_q    <= k_c;
				m_q    <= log_x_q << (5'd31 - k_c);
				frac_q <= '0;
				step_q <= '0;
			end
			ST_LOG_SQ: begin
				step_q <= step_q + 1'b1;
				if (prod[63]) begin
					m_q    <= prod[63:32];
					frac_q <= {frac_q[LogFracBits-2:0], 1'b1};
				end else begin
					m_q    <= prod[62:31];
					frac_q <= {frac_q[LogFracBits-2:0], 1'b0};
				end
			end
			ST_CLOG: begin
				clog_q <= clog_q + prod;
				i_q    <= i_q + 1'b1;
			end
			ST_FIN: begin
				ent_q   <= 1'b0;
				imb_q   <= 1'b0;
				log_x_q <= total_q;
				kind_q  <= LOG_TOT;
			end
			ST_TL: begin
				s_q     <= prod - clog_q;
				log_x_q <= 32'(n_q);
				kind_q  <= LOG_N;
			end
			ST_M1: a_q <= prod[39:0];
			ST_M2: rhs_q <= 80'(prod);
			ST_M3: rhs_q <= rhs_q + {prod[47:0], 32'd0};
			ST_M4: begin
				ent_q <= {s_q, 16'd0} > rhs_q;
				nm_q  <= prod[39:0];
			end
			ST_M5: b_q <= prod[24:0];
			ST_M6: rhs_q <= 80'(prod);
			ST_M7: imb_q <= 80'({nm_q - 40'(total_q), 16'd0}) > rhs_q;
			ST_OUT: begin
				if (out_free) begin
					out_q <= {5'd0, total_q, imb_q, ent_q, ent_q | imb_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: design/ecp_checker.sv
// Port-level checks for the expert usage checkpoint policy block, bound to the top level.
`timescale 1ns / 1ps
module ecp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result request changed.");

	a_or: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] | m_axis_tdata[2]))
		else $error("Checkpoint flag is not the OR of the two tests.");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:3] == 32'd0) |-> m_axis_tdata[2:0] == 3'd0)
		else $error("Flags raised with a zero usage total.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input ready stayed high after an accepted request.");

endmodule

bind expert_usage_checkpoint_policy_core ecp_checker u_ecp_checker (.*);
